/* rtl/uer_pkg.sv */
// ----------------------------------------------------------------------------
// uer_pkg : shared types and constants for the ultrasonic echo ranging block
// Field widths, configuration register indices, status codes, reset values
// of the configuration registers and the structs passed between modules.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Field and counter widths
  localparam int TICK_W  = 20;
  localparam int TRIG_W  = 16;
  localparam int DIST_W  = 16;
  localparam int SUM_W   = 19;
  localparam int SHOT_W  = 3;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 3;

  // Shots per measurement
  localparam logic [SHOT_W-1:0] SHOTS = 3'd6;

  // Width to millimetres: mm = floor(width * MM_NUM / MM_DEN), built up
  // one tick at a time with a running remainder
  localparam int REM_W = 12;
  localparam int MMQ_W = 18;
  localparam logic [REM_W-1:0] MM_NUM = 12'd343;
  localparam logic [REM_W-1:0] MM_DEN = 12'd2000;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POWER_OK = 3'd0,
    CFG_TRIGGER  = 3'd1,
    CFG_TIMEOUT  = 3'd2,
    CFG_GAP      = 3'd3,
    CFG_MIN_DIST = 3'd4,
    CFG_MAX_DIST = 3'd5
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_t;

  // Configuration reset values
  localparam logic [TRIG_W-1:0] RST_TRIGGER  = 16'd1000;
  localparam logic [TICK_W-1:0] RST_TIMEOUT  = 20'd1000000;
  localparam logic [TICK_W-1:0] RST_GAP      = 20'd50000;
  localparam logic [DIST_W-1:0] RST_MIN_DIST = 16'd240;
  localparam logic [DIST_W-1:0] RST_MAX_DIST = 16'd6000;

  typedef struct packed {
    logic              power_ok;
    logic [TRIG_W-1:0] trigger_ticks;
    logic [TICK_W-1:0] timeout_ticks;
    logic [TICK_W-1:0] gap_ticks;
    logic [DIST_W-1:0] min_distance;
    logic [DIST_W-1:0] max_distance;
  } cfg_t;

  // Control from the sequencer to the width converter
  typedef struct packed {
    logic load;
    logic step;
  } mm_ctl_t;

  // One result transaction
  typedef struct packed {
    logic              trigger;
    logic              done;
    logic [DIST_W-1:0] distance;
    status_t           status;
    logic              busy;
  } result_t;

endpackage

/* rtl/uer_cfg_regs.sv */
// ----------------------------------------------------------------------------
// uer_cfg_regs : configuration register file
// Six write-only registers loaded through a plain write port.
// ----------------------------------------------------------------------------
module uer_cfg_regs import uer_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POWER_OK: cfg_nxt.power_ok      = cfg_wdata[0];
        CFG_TRIGGER:  cfg_nxt.trigger_ticks = cfg_wdata[TRIG_W-1:0];
        CFG_TIMEOUT:  cfg_nxt.timeout_ticks = cfg_wdata[TICK_W-1:0];
        CFG_GAP:      cfg_nxt.gap_ticks     = cfg_wdata[TICK_W-1:0];
        CFG_MIN_DIST: cfg_nxt.min_distance  = cfg_wdata[DIST_W-1:0];
        CFG_MAX_DIST: cfg_nxt.max_distance  = cfg_wdata[DIST_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_ok      <= 1'b1;
      cfg_r.trigger_ticks <= RST_TRIGGER;
      cfg_r.timeout_ticks <= RST_TIMEOUT;
      cfg_r.gap_ticks     <= RST_GAP;
      cfg_r.min_distance  <= RST_MIN_DIST;
      cfg_r.max_distance  <= RST_MAX_DIST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/uer_mm_conv.sv */
// ----------------------------------------------------------------------------
// uer_mm_conv : echo width to millimetre converter
// Tracks floor(width * 343 / 2000) as the echo-high width grows, one tick at
// a time, with a quotient and a running remainder. Saturates at 65535.
// ----------------------------------------------------------------------------
module uer_mm_conv import uer_pkg::*; (
  input  logic              clk,
  input  mm_ctl_t           ctl,
  output logic [DIST_W-1:0] mm
);

  logic [MMQ_W-1:0] quot_r;
  logic [MMQ_W-1:0] quot_nxt;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic [REM_W-1:0] rem_sum;

  // Width one on load, one more tick on each step
  always_comb begin
    rem_sum  = rem_r + MM_NUM;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (ctl.load) begin
      quot_nxt = '0;
      rem_nxt  = MM_NUM;
    end else if (ctl.step) begin
      if (rem_sum >= MM_DEN) begin
        rem_nxt  = rem_sum - MM_DEN;
        quot_nxt = quot_r + MMQ_W'(1);
      end else begin
        rem_nxt  = rem_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  // Saturate to the distance field
  assign mm = (|quot_r[MMQ_W-1:DIST_W]) ? '1 : quot_r[DIST_W-1:0];

endmodule

/* rtl/uer_seq.sv */
// ----------------------------------------------------------------------------
// uer_seq : measurement sequencer
// Steps trigger, echo-rise wait, echo-high count and gap for six shots,
// keeps the sum, minimum and maximum of the shot distances and forms the
// result of each tick.
// ----------------------------------------------------------------------------
module uer_seq import uer_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              start_req,
  input  logic              echo,
  input  cfg_t              cfg,
  input  logic [DIST_W-1:0] mm,
  output mm_ctl_t           mm_ctl,
  output result_t           res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_RISE = 3'd2,
    PH_HIGH = 3'd3,
    PH_GAP  = 3'd4
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [SHOT_W-1:0] shot_r, shot_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DIST_W-1:0] min_r, min_nxt;
  logic [DIST_W-1:0] max_r, max_nxt;
  mm_ctl_t           ctl;

  always_comb begin
    logic [TICK_W-1:0] tmo;
    logic [TRIG_W-1:0] trig_len;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] trig_cnt;
    logic [SHOT_W-1:0] shot_inc;
    logic [SUM_W-1:0]  mid_sum;
    logic [SUM_W-3:0]  avg;

    tmo      = (cfg.timeout_ticks == '0) ? TICK_W'(1) : cfg.timeout_ticks;
    trig_len = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;
    tick_inc = tick_r + TICK_W'(1);
    shot_inc = shot_r + SHOT_W'(1);
    trig_cnt = '0;

    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    shot_nxt  = shot_r;
    sum_nxt   = sum_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    ctl       = '0;
    res       = '0;
    res.status = ST_OK;

    // Shot statistics with this tick's distance folded in
    if (mm < min_r) min_nxt = mm;
    if (mm > max_r) max_nxt = mm;
    mid_sum = sum_r + SUM_W'(mm);
    mid_sum = mid_sum - SUM_W'(min_nxt) - SUM_W'(max_nxt);
    avg     = mid_sum[SUM_W-1:2];
    min_nxt = min_r;
    max_nxt = max_r;

    case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          if (echo || !cfg.power_ok) begin
            res.done     = 1'b1;
            res.distance = '1;
            res.status   = ST_NOT_READY;
          end else begin
            shot_nxt  = '0;
            sum_nxt   = '0;
            min_nxt   = '1;
            max_nxt   = '0;
            tick_nxt  = '0;
            phase_nxt = PH_TRIG;
          end
        end
      end
      PH_RISE: begin
        if (echo) begin
          tick_nxt  = TICK_W'(1);
          phase_nxt = PH_HIGH;
          ctl.load  = 1'b1;
          if (TICK_W'(1) >= tmo) begin
            res.done   = 1'b1;
            res.status = ST_TIMEOUT;
            phase_nxt  = PH_IDLE;
          end
        end else begin
          tick_nxt = tick_inc;
          if (tick_inc >= tmo) begin
            res.done   = 1'b1;
            res.status = ST_TIMEOUT;
            phase_nxt  = PH_IDLE;
          end
        end
      end
      PH_HIGH: begin
        if (echo) begin
          tick_nxt = tick_inc;
          ctl.step = 1'b1;
          if (tick_inc >= tmo) begin
            res.done   = 1'b1;
            res.status = ST_TIMEOUT;
            phase_nxt  = PH_IDLE;
          end
        end else begin
          // Falling edge: close the shot
          sum_nxt  = sum_r + SUM_W'(mm);
          if (mm < min_r) min_nxt = mm;
          if (mm > max_r) max_nxt = mm;
          shot_nxt = shot_inc;
          tick_nxt = '0;
          if (shot_inc >= SHOTS) begin
            res.done  = 1'b1;
            phase_nxt = PH_IDLE;
            if (avg < (SUM_W-2)'(cfg.min_distance) ||
                avg > (SUM_W-2)'(cfg.max_distance)) begin
              res.status = ST_RANGE;
            end else begin
              res.distance = avg[DIST_W-1:0];
              res.status   = ST_OK;
            end
          end else begin
            phase_nxt = (cfg.gap_ticks == '0) ? PH_TRIG : PH_GAP;
          end
        end
      end
      PH_GAP: begin
        tick_nxt = tick_inc;
        if (tick_inc >= cfg.gap_ticks) begin
          tick_nxt  = '0;
          phase_nxt = PH_TRIG;
        end
      end
      PH_TRIG: begin
        phase_nxt = PH_TRIG;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // Trigger pulse, also on the tick that enters it
    if (phase_nxt == PH_TRIG && !res.done) begin
      res.trigger = 1'b1;
      trig_cnt    = tick_nxt + TICK_W'(1);
      tick_nxt    = trig_cnt;
      if (trig_cnt >= TICK_W'(trig_len)) begin
        tick_nxt  = '0;
        phase_nxt = PH_RISE;
      end
    end

    res.busy = (phase_nxt != PH_IDLE);
  end

  // Advance only when a transaction is processed
  assign mm_ctl.load = ctl.load & en;
  assign mm_ctl.step = ctl.step & en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      shot_r  <= '0;
      sum_r   <= '0;
      min_r   <= '1;
      max_r   <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      shot_r  <= shot_nxt;
      sum_r   <= sum_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

endmodule

/* rtl/ultrasonic_echo_ranging.sv */
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranging : ultrasonic time-of-flight ranging controller
// Six-shot echo measurement with min/max rejection and range limits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction per microsecond
//   tick, carrying the start request and the sampled echo level.
//   Output channel (out_valid / out_stall): exactly one transaction per
//   input tick, carrying the trigger level, busy flag and, on the tick a
//   measurement finishes, done_res with distance_mm and status.
//   Configuration (cfg_we / cfg_index / cfg_wdata): write while idle.
//   Path: an accepted tick is held in the input register, processed into the
//   result register when that register is free or draining, and offered from there.
//   Throughput: one tick per cycle unless a stalled full result register holds
//   the input register; the sequencer state update is a single short step.
//   Reset: synchronous, active low; the sequencer returns to idle, the
//   configuration takes its default values and both registers empty.
//   Stall: while out_stall holds a full result register, the input
//   register holds too and in_stall rises once it is full.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranging import uer_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_start_req,
  input  logic                 in_echo,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_trigger,
  output logic                 out_done_res,
  output logic [DIST_W-1:0]    out_distance_mm,
  output logic [1:0]           out_status,
  output logic                 out_busy_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t              cfg;
  mm_ctl_t           mm_ctl;
  logic [DIST_W-1:0] mm;
  result_t           res;

  logic    in_vld_r;
  logic    start_r;
  logic    echo_r;
  logic    out_vld_r;
  result_t out_r;
  logic    advance;

  // Process the held tick when the result register is free or draining
  assign advance  = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall = in_vld_r && !advance;

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uer_mm_conv u_conv (
    .clk (clk),
    .ctl (mm_ctl),
    .mm  (mm)
  );

  uer_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .start_req (start_r),
    .echo      (echo_r),
    .cfg       (cfg),
    .mm        (mm),
    .mm_ctl    (mm_ctl),
    .res       (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      start_r <= in_start_req;
      echo_r  <= in_echo;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_trigger     = out_r.trigger;
  assign out_done_res    = out_r.done;
  assign out_distance_mm = out_r.distance;
  assign out_status      = out_r.status;
  assign out_busy_res    = out_r.busy;

endmodule

/* rtl/uer_checker.sv */
// ----------------------------------------------------------------------------
// uer_checker : port-level checks for the ranging block
// Watches the result channel and checks result coding over time.
// ----------------------------------------------------------------------------
module uer_checker import uer_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_trigger,
  input logic                 out_done_res,
  input logic [DIST_W-1:0]    out_distance_mm,
  input logic [1:0]           out_status,
  input logic                 out_busy_res
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance_mm) &&
      $stable(out_status) && $stable(out_done_res))
    else $error("stalled result transaction changed");

  // Clear result fields on ticks without a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_distance_mm == '0 && out_status == ST_OK)
    else $error("result fields set without done");

  // Not ready reports full scale and leaves the block idle
  a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res && out_status == ST_NOT_READY |->
      out_distance_mm == '1 && !out_busy_res && !out_trigger)
    else $error("bad not-ready result");

  // Trigger only while busy; failures report zero distance
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger |-> out_busy_res && !out_done_res)
    else $error("trigger outside a running sequence");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res &&
      (out_status == ST_TIMEOUT || out_status == ST_RANGE) |->
      out_distance_mm == '0 && !out_busy_res)
    else $error("failed measurement with nonzero distance");

endmodule

bind ultrasonic_echo_ranging uer_checker u_uer_checker (.*);

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench : ultrasonic echo ranging controller
// Drives microsecond ticks (start request, echo level) through the valid and
// stall handshake and checks every result transaction against a cycle model
// of the six-shot sequencer kept in this file. Directed tests cover not-ready
// starts, rise and width timeouts, range limits and the register extremes.
// Random tests mix well-formed shot sequences with noise under three
// flow-control patterns.
// ----------------------------------------------------------------------------
module testbench;
  import uer_pkg::*;

  localparam logic [DIST_W-1:0] NOT_READY_MM = 16'hFFFF;
  localparam int unsigned MIDDLE_SHOTS = 4;
  localparam int unsigned MAX_PRINTS = 40;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TRIG, PH_RISE, PH_HIGH, PH_GAP
  } ranger_phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_start_req = 1'b0;
  logic                 in_echo = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_trigger;
  logic                 out_done_res;
  logic [DIST_W-1:0]    out_distance_mm;
  logic [1:0]           out_status;
  logic                 out_busy_res;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Sequencer model state and its copy of the registers
  ranger_phase_t     seq_phase = PH_IDLE;
  logic [TICK_W-1:0] tick_cnt = '0;
  logic [SHOT_W-1:0] shot_cnt = '0;
  logic [SUM_W-1:0]  mm_sum = '0;
  logic [DIST_W-1:0] mm_min = '1;
  logic [DIST_W-1:0] mm_max = '0;
  cfg_t              ranging_cfg;

  result_t     tick_outcomes[$];
  int unsigned echo_widths[6];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned meas_done = 0;
  int unsigned timeouts_seen = 0;
  int unsigned not_ready_seen = 0;

  ultrasonic_echo_ranging uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_req(in_start_req),
    .in_echo(in_echo),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_trigger(out_trigger),
    .out_done_res(out_done_res),
    .out_distance_mm(out_distance_mm),
    .out_status(out_status),
    .out_busy_res(out_busy_res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the sequencer model by one tick and return what it presents
  function automatic result_t ranger_tick(input logic start, input logic echo);
    result_t           r;
    logic [TICK_W-1:0] tmo_eff;
    logic [TICK_W-1:0] trig_eff;
    int unsigned       mm;
    int unsigned       avg;
    r = '0;
    tmo_eff = (ranging_cfg.timeout_ticks == '0) ? TICK_W'(1) : ranging_cfg.timeout_ticks;
    trig_eff = (ranging_cfg.trigger_ticks == '0) ? TICK_W'(1) :
               TICK_W'(ranging_cfg.trigger_ticks);
    case (seq_phase)
      PH_IDLE: begin
        if (start) begin
          if (echo || !ranging_cfg.power_ok) begin
            r.done = 1'b1;
            r.distance = NOT_READY_MM;
            r.status = ST_NOT_READY;
          end else begin
            shot_cnt = '0;
            mm_sum = '0;
            mm_min = '1;
            mm_max = '0;
            tick_cnt = '0;
            seq_phase = PH_TRIG;
          end
        end
      end
      PH_RISE: begin
        // the first high tick already counts as width one
        if (echo) begin
          tick_cnt = TICK_W'(1);
          seq_phase = PH_HIGH;
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
        if (tick_cnt >= tmo_eff) begin
          r.done = 1'b1;
          r.status = ST_TIMEOUT;
          seq_phase = PH_IDLE;
        end
      end
      PH_HIGH: begin
        if (echo) begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= tmo_eff) begin
            r.done = 1'b1;
            r.status = ST_TIMEOUT;
            seq_phase = PH_IDLE;
          end
        end else begin
          // falling tick: convert the width and fold it into the shot record
          mm = (32'(tick_cnt) * 32'(MM_NUM)) / 32'(MM_DEN);
          if (mm > 32'(NOT_READY_MM)) mm = 32'(NOT_READY_MM);
          mm_sum = mm_sum + SUM_W'(mm);
          if (mm < 32'(mm_min)) mm_min = DIST_W'(mm);
          if (mm > 32'(mm_max)) mm_max = DIST_W'(mm);
          shot_cnt = shot_cnt + 1'b1;
          tick_cnt = '0;
          if (shot_cnt >= SHOTS) begin
            avg = (32'(mm_sum) - 32'(mm_min) - 32'(mm_max)) / MIDDLE_SHOTS;
            r.done = 1'b1;
            if (avg < 32'(ranging_cfg.min_distance) || avg > 32'(ranging_cfg.max_distance)) begin
              r.status = ST_RANGE;
            end else begin
              r.distance = DIST_W'(avg);
              r.status = ST_OK;
            end
            seq_phase = PH_IDLE;
          end else begin
            seq_phase = (ranging_cfg.gap_ticks == '0) ? PH_TRIG : PH_GAP;
          end
        end
      end
      PH_GAP: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= ranging_cfg.gap_ticks) begin
          tick_cnt = '0;
          seq_phase = PH_TRIG;
        end
      end
      default: ;
    endcase
    // trigger pulse, including the start tick itself
    if (seq_phase == PH_TRIG && !r.done) begin
      r.trigger = 1'b1;
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= trig_eff) begin
        tick_cnt = '0;
        seq_phase = PH_RISE;
      end
    end
    r.busy = (seq_phase != PH_IDLE);
    if (r.done) begin
      case (r.status)
        ST_TIMEOUT:   timeouts_seen++;
        ST_NOT_READY: not_ready_seen++;
        default:      meas_done++;
      endcase
    end
    return r;
  endfunction

  function automatic cfg_t make_cfg(input int unsigned power, input int unsigned trig,
                                    input int unsigned tmo, input int unsigned gap,
                                    input int unsigned lo, input int unsigned hi);
    cfg_t c;
    c.power_ok = power[0];
    c.trigger_ticks = TRIG_W'(trig);
    c.timeout_ticks = TICK_W'(tmo);
    c.gap_ticks = TICK_W'(gap);
    c.min_distance = DIST_W'(lo);
    c.max_distance = DIST_W'(hi);
    return c;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  task automatic check_tick_result();
    result_t want;
    if (tick_outcomes.size() == 0) begin
      flag_mismatch("result with nothing pending", 32'(out_done_res), 32'd0);
    end else begin
      want = tick_outcomes.pop_front();
      if (out_trigger !== want.trigger)
        flag_mismatch("trigger", 32'(out_trigger), 32'(want.trigger));
      if (out_done_res !== want.done)
        flag_mismatch("done_res", 32'(out_done_res), 32'(want.done));
      if (out_distance_mm !== want.distance)
        flag_mismatch("distance_mm", 32'(out_distance_mm), 32'(want.distance));
      if (out_status !== want.status)
        flag_mismatch("status", 32'(out_status), 32'(want.status));
      if (out_busy_res !== want.busy)
        flag_mismatch("busy_res", 32'(out_busy_res), 32'(want.busy));
    end
    results_seen++;
  endtask

  // Result side: take each transaction, then pick the stall for the next edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_tick_result();
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one tick, hold it until taken, then advance the model
  task automatic send_tick(input logic start, input logic echo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    in_echo <= echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tick_outcomes.push_back(ranger_tick(start, echo));
    ticks_sent++;
  endtask

  // Finish whatever sequence is running: raise echo in the rise wait, drop it otherwise
  task automatic drain_to_idle();
    while (seq_phase != PH_IDLE) send_tick(1'b0, seq_phase == PH_RISE);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (tick_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    cfg_idx_t idx;
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      case (idx)
        CFG_POWER_OK: cfg_wdata <= CFG_W'(c.power_ok);
        CFG_TRIGGER:  cfg_wdata <= CFG_W'(c.trigger_ticks);
        CFG_TIMEOUT:  cfg_wdata <= CFG_W'(c.timeout_ticks);
        CFG_GAP:      cfg_wdata <= CFG_W'(c.gap_ticks);
        CFG_MIN_DIST: cfg_wdata <= CFG_W'(c.min_distance);
        CFG_MAX_DIST: cfg_wdata <= CFG_W'(c.max_distance);
        default:      cfg_wdata <= '0;
      endcase
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    ranging_cfg = c;
  endtask

  task automatic reconfigure(input cfg_t c);
    drain_to_idle();
    quiesce();
    apply_config(c);
  endtask

  // Start a measurement and play the echo widths in echo_widths; noisy adds
  // ignored starts and echo pulses, and a random rise wait up to rise_wait
  task automatic run_measurement(input int unsigned rise_wait, input bit noisy);
    int unsigned dly;
    int          s;
    int unsigned k;
    send_tick(1'b1, 1'b0);
    for (s = 0; s < 6; s++) begin
      while (seq_phase == PH_TRIG || seq_phase == PH_GAP)
        send_tick(noisy && $urandom_range(1), noisy && $urandom_range(1));
      if (seq_phase != PH_RISE) return;
      dly = noisy ? $urandom_range(rise_wait) : rise_wait;
      for (k = 0; k < dly && seq_phase == PH_RISE; k++)
        send_tick(noisy && $urandom_range(1), 1'b0);
      for (k = 0; k < echo_widths[s] && (seq_phase == PH_RISE || seq_phase == PH_HIGH); k++)
        send_tick(noisy && $urandom_range(1), 1'b1);
      if (seq_phase == PH_HIGH) send_tick(noisy && $urandom_range(1), 1'b0);
    end
  endtask

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c = make_cfg($urandom_range(7) != 0, $urandom_range(3),
                 ($urandom_range(4) == 0) ? $urandom_range(1, 8) : $urandom_range(30, 700),
                 $urandom_range(4), $urandom_range(3), $urandom_range(8));
    if ($urandom_range(5) == 0) begin
      c.min_distance = '0;
      c.max_distance = '1;
    end
    return c;
  endfunction

  // Echo already high at start, then sensor power off
  task automatic test_not_ready();
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    reconfigure(make_cfg(0, 4, 16, 2, 0, 65535));
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  // Rise wait and echo width running out; zero trigger and timeout act as one
  task automatic test_timeouts();
    reconfigure(make_cfg(1, 0, 0, 0, 0, 65535));
    echo_widths = '{1, 1, 1, 1, 1, 1};
    run_measurement(1, 1'b0);
    run_measurement(0, 1'b0);
    reconfigure(make_cfg(1, 1, 3, 1, 0, 65535));
    echo_widths = '{2, 5, 1, 1, 1, 1};
    run_measurement(0, 1'b0);
    run_measurement(3, 1'b0);
  endtask

  // Complete measurements against in-range, below, above and crossed limits;
  // the middle four distances average to 3 mm
  task automatic test_measurements();
    echo_widths = '{1, 6, 12, 24, 30, 30};
    reconfigure(make_cfg(1, 2, 1048575, 0, 0, 65535));
    run_measurement(0, 1'b0);
    reconfigure(make_cfg(1, 0, 300, 3, 5, 65535));
    run_measurement(2, 1'b0);
    reconfigure(make_cfg(1, 1, 300, 1, 0, 2));
    run_measurement(1, 1'b0);
    reconfigure(make_cfg(1, 3, 300, 2, 3, 3));
    run_measurement(1, 1'b0);
    run_measurement(3, 1'b1);
    reconfigure(make_cfg(1, 1, 300, 2, 5, 3));
    run_measurement(1, 1'b0);
  endtask

  // Mostly well-formed sequences with random widths, some bursts of noise
  task automatic test_random(input int unsigned n_ticks);
    int unsigned first_tick;
    int unsigned per_cfg;
    first_tick = ticks_sent;
    per_cfg = 0;
    reconfigure(rand_cfg());
    while (ticks_sent - first_tick < n_ticks) begin
      if (per_cfg == 8) begin
        reconfigure(rand_cfg());
        per_cfg = 0;
      end
      per_cfg++;
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(1, 12))
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        foreach (echo_widths[i])
          echo_widths[i] = ($urandom_range(7) == 0) ? $urandom_range(25, 200) :
                           $urandom_range(1, 24);
        run_measurement($urandom_range(4), $urandom_range(1));
      end
    end
  endtask

  // Long trigger pulse, widest gap written, then a rise wait that times out at once
  task automatic test_long_trigger();
    reconfigure(make_cfg(1, 120, 1, 1048575, 65535, 0));
    echo_widths = '{1, 1, 1, 1, 1, 1};
    run_measurement(1, 1'b0);
  endtask

  initial begin
    ranging_cfg = make_cfg(1, RST_TRIGGER, RST_TIMEOUT, RST_GAP, RST_MIN_DIST, RST_MAX_DIST);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_stall_pct = 67;
    test_not_ready();
    test_timeouts();
    test_measurements();
    test_random(200);

    send_idle_pct = 67;
    recv_stall_pct = 15;
    test_random(200);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(200);
    test_long_trigger();

    drain_to_idle();
    quiesce();
    $display("%0d ticks checked: %0d measurements finished, %0d echo timeouts, %0d not ready",
             results_seen, meas_done, timeouts_seen, not_ready_seen);
    $display("register extremes and three flow-control patterns exercised");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hold a hard ceiling on run time
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
